// ----- sv/furf_pkg.sv -----
`timescale 1ns / 1ps

package furf_pkg;

    // Field widths
    localparam int DATA_BITS         = 8;
    localparam int OUT_BITS          = 48;
    localparam int POSITION_BITS_DEF = 48;

    // Characters the parser looks for
    localparam logic [DATA_BITS-1:0] CH_HEADER  = 8'h3E;  // '>'
    localparam logic [DATA_BITS-1:0] CH_NEWLINE = 8'h0A;  // '\n'
    localparam logic [DATA_BITS-1:0] CH_UP_A    = 8'h41;
    localparam logic [DATA_BITS-1:0] CH_UP_C    = 8'h43;
    localparam logic [DATA_BITS-1:0] CH_UP_G    = 8'h47;
    localparam logic [DATA_BITS-1:0] CH_UP_T    = 8'h54;
    localparam logic [DATA_BITS-1:0] CH_LO_A    = 8'h61;
    localparam logic [DATA_BITS-1:0] CH_LO_C    = 8'h63;
    localparam logic [DATA_BITS-1:0] CH_LO_G    = 8'h67;
    localparam logic [DATA_BITS-1:0] CH_LO_T    = 8'h74;

    // Input request: one byte of text
    typedef struct packed {
        logic [DATA_BITS-1:0] data_byte;
        logic                 end_of_stream;
    } t_in_req;

    // Output request: one undefined run
    typedef struct packed {
        logic [OUT_BITS-1:0] run_start;
        logic [OUT_BITS-1:0] run_end;
        logic [OUT_BITS-1:0] run_length;
    } t_out_req;

    // A, C, G or T in either case
    function automatic logic is_defined_base(input logic [DATA_BITS-1:0] b);
        is_defined_base = b inside {CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T,
                                    CH_LO_A, CH_LO_C, CH_LO_G, CH_LO_T};
    endfunction

endpackage

// ----- sv/fasta_undefined_run_finder_core.sv -----
`timescale 1ns / 1ps

// Scans FASTA text one byte per request and reports each run of bases that
// are not A, C, G or T (either case). Header lines ('>' through newline) and
// newlines are skipped; every other byte is a base at a 1-based position
// that saturates at 2^POSITION_BITS - 1. A run is reported when a defined
// base ends it, or after the byte marked end_of_stream, which also returns
// the block to its reset state. One byte is taken every clock cycle while the
// result side does not stall; a byte passes an input register and one stage
// of parse logic into the result register. Both sides stall through
// valid/ready; while a result waits unaccepted the parse stage holds, so
// the input register takes at most one more byte and then the input stalls
// until the result is taken.
module fasta_undefined_run_finder_core
    import furf_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Registers
    logic                     r_in_valid;
    t_in_req                  r_in;
    logic                     r_out_valid;
    t_out_req                 r_out;
    logic                     r_header;
    logic                     r_open;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_start;

    logic                     n_header;
    logic                     n_open;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_start;

    logic                     w_advance;
    logic                     w_emit;
    logic [POSITION_BITS-1:0] w_emit_start;
    logic [POSITION_BITS-1:0] w_emit_pos;
    logic [POSITION_BITS-1:0] w_last_raw;
    logic [POSITION_BITS-1:0] w_last;
    logic [POSITION_BITS-1:0] w_length;

    // Stage handshakes
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Parse one byte against the current state
    always_comb begin
        logic                     b_open;
        logic [POSITION_BITS-1:0] b_pos;
        logic [POSITION_BITS-1:0] b_start;
        logic                     b_emit;

        n_header = r_header;
        b_open   = r_open;
        b_pos    = r_pos;
        b_start  = r_start;
        b_emit   = 1'b0;

        if (r_header) begin
            if (r_in.data_byte == CH_NEWLINE) begin
                n_header = 1'b0;
            end
        end else if (r_in.data_byte == CH_HEADER) begin
            n_header = 1'b1;
        end else if (r_in.data_byte != CH_NEWLINE) begin
            if (!is_defined_base(r_in.data_byte)) begin
                if (!r_open) begin
                    b_open  = 1'b1;
                    b_start = r_pos;
                end
            end else if (r_open) begin
                // defined base closes the run
                b_emit = 1'b1;
                b_open = 1'b0;
            end
            if (r_pos != POS_MAX) begin
                b_pos = r_pos + POS_ONE;
            end
        end

        w_emit       = b_emit;
        w_emit_start = b_start;
        w_emit_pos   = b_emit ? r_pos : b_pos;
        n_open       = b_open;
        n_pos        = b_pos;
        n_start      = b_start;

        // End of stream: flush open run, back to reset state
        if (r_in.end_of_stream) begin
            if (b_open) begin
                w_emit = 1'b1;
            end
            n_header = 1'b0;
            n_open   = 1'b0;
            n_pos    = POS_ONE;
            n_start  = '0;
        end
    end

    // Run bounds; end clamps to start when the position has saturated
    assign w_last_raw = w_emit_pos - POS_ONE;
    assign w_last     = (w_last_raw < w_emit_start) ? w_emit_start : w_last_raw;
    assign w_length   = w_last - w_emit_start + POS_ONE;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 1'b0;
            r_open   <= 1'b0;
            r_pos    <= POS_ONE;
            r_start  <= '0;
        end else if (w_advance) begin
            r_header <= n_header;
            r_open   <= n_open;
            r_pos    <= n_pos;
            r_start  <= n_start;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_emit) begin
            r_out.run_start  <= OUT_BITS'(w_emit_start);
            r_out.run_end    <= OUT_BITS'(w_last);
            r_out.run_length <= OUT_BITS'(w_length);
        end
    end

`ifndef NO_ASSERTIONS
    // A reported run is never empty and starts at a real position
    a_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.run_start != '0 && r_out.run_length != '0))
        else $error("run reported with zero start or length");

    // Length agrees with the bounds
    a_length_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_out.run_length == OUT_BITS'(r_out.run_end - r_out.run_start + 1'b1)))
        else $error("run length does not match bounds");

    // End of stream returns the parser to its reset state
    a_eos_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.end_of_stream) |=> (r_pos == POS_ONE && !r_open && !r_header))
        else $error("parser state not cleared after end of stream");

    // No new result may overwrite one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_advance)
        else $error("parse stage advanced into a stalled result");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
    import furf_pkg::*;
();

    localparam int POS_BITS = POSITION_BITS_DEF;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 400;

    // Bytes used to build sequence text
    localparam logic [DATA_BITS-1:0] CH_UP_N = 8'h4E;
    localparam logic [DATA_BITS-1:0] CH_LO_N = 8'h6E;
    localparam logic [DATA_BITS-1:0] CH_UP_X = 8'h58;
    localparam logic [DATA_BITS-1:0] CH_LO_Q = 8'h71;
    localparam logic [DATA_BITS-1:0] CH_ZERO = 8'h00;
    localparam logic [DATA_BITS-1:0] CH_HIGH = 8'hFF;
    localparam logic [DATA_BITS-1:0] CH_MSB  = 8'h80;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_req o_out_data;

    fasta_undefined_run_finder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent and runs waiting to be reported
    t_in_req  text_q[$];
    t_out_req run_q[$];

    int  snd_idle_pct  = 0;
    int  rcv_stall_pct = 0;
    int  rcv_hold      = 0;
    bit  in_taken      = 1'b0;
    int  n_bytes       = 0;
    int  n_runs        = 0;
    int  n_errors      = 0;

    // Scanner state mirrored in the testbench
    bit                in_header;
    bit                run_open;
    logic [POS_BITS-1:0] base_pos;
    logic [POS_BITS-1:0] run_first;

    function automatic bit is_acgt(input logic [DATA_BITS-1:0] b);
        case (b)
            CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T,
            CH_LO_A, CH_LO_C, CH_LO_G, CH_LO_T: is_acgt = 1'b1;
            default:                            is_acgt = 1'b0;
        endcase
    endfunction

    function automatic void scanner_reset();
        in_header = 1'b0;
        run_open  = 1'b0;
        base_pos  = POS_BITS'(1);
        run_first = '0;
    endfunction

    // Close the open run; its last base is the one before base_pos
    function automatic t_out_req close_run();
        logic [POS_BITS-1:0] last;
        t_out_req r;
        last = base_pos - 1'b1;
        if (last < run_first) last = run_first;
        r.run_start  = run_first[OUT_BITS-1:0];
        r.run_end    = last[OUT_BITS-1:0];
        r.run_length = OUT_BITS'(last - run_first + 1'b1);
        run_open = 1'b0;
        return r;
    endfunction

    // Advance the scanner by one byte; returns 1 when a run is reported
    function automatic bit scan_byte(input t_in_req req, output t_out_req run);
        bit hit;
        hit = 1'b0;
        run = '0;
        if (in_header) begin
            if (req.data_byte == CH_NEWLINE) in_header = 1'b0;
        end else if (req.data_byte == CH_HEADER) begin
            in_header = 1'b1;
        end else if (req.data_byte != CH_NEWLINE) begin
            if (!is_acgt(req.data_byte)) begin
                if (!run_open) begin
                    run_open  = 1'b1;
                    run_first = base_pos;
                end
            end else if (run_open) begin
                run = close_run();
                hit = 1'b1;
            end
            if (base_pos < POS_MAX) base_pos = base_pos + 1'b1;
        end
        if (req.end_of_stream) begin
            if (run_open) begin
                run = close_run();
                hit = 1'b1;
            end
            scanner_reset();
        end
        return hit;
    endfunction

    task automatic put(input logic [DATA_BITS-1:0] b, input bit eos);
        t_in_req r;
        r.data_byte     = b;
        r.end_of_stream = eos;
        text_q.push_back(r);
    endtask

    function automatic logic [DATA_BITS-1:0] undef_byte();
        logic [DATA_BITS-1:0] b;
        if ($urandom_range(99) < 50) return ($urandom_range(1) != 0) ? CH_UP_N : CH_LO_N;
        do b = DATA_BITS'($urandom_range(255));
        while (is_acgt(b) || b == CH_HEADER || b == CH_NEWLINE);
        return b;
    endfunction

    function automatic logic [DATA_BITS-1:0] acgt_byte();
        case ($urandom_range(7))
            0: return CH_UP_A;
            1: return CH_UP_C;
            2: return CH_UP_G;
            3: return CH_UP_T;
            4: return CH_LO_A;
            5: return CH_LO_C;
            6: return CH_LO_G;
            default: return CH_LO_T;
        endcase
    endfunction

    // One FASTA record with random content, or a burst of raw noise
    task automatic add_record();
        int n_lines;
        int line_len;
        int k;
        t_in_req last;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 10))
                put(DATA_BITS'($urandom_range(255)), $urandom_range(99) < 10);
        end else begin
            if ($urandom_range(99) < 30) begin
                put(CH_HEADER, 1'b0);
                repeat ($urandom_range(0, 12)) put(DATA_BITS'($urandom_range(32, 126)), 1'b0);
                put(CH_NEWLINE, 1'b0);
            end
            n_lines = $urandom_range(1, 4);
            for (int ln = 0; ln < n_lines; ln++) begin
                line_len = $urandom_range(1, 20);
                k = 0;
                while (k < line_len) begin
                    if ($urandom_range(99) < 20) begin
                        repeat ($urandom_range(1, 6)) put(undef_byte(), 1'b0);
                    end else begin
                        put(acgt_byte(), 1'b0);
                    end
                    k++;
                end
                if (ln < n_lines - 1 || $urandom_range(1) != 0) put(CH_NEWLINE, 1'b0);
            end
            if ($urandom_range(99) < 25) begin
                last = text_q.pop_back();
                last.end_of_stream = 1'b1;
                text_q.push_back(last);
            end
        end
    endtask

    task automatic fill_random(input int count);
        int start_sz;
        start_sz = text_q.size();
        while (text_q.size() - start_sz < count) add_record();
    endtask

    // Wait until every byte is taken and every run is reported
    task automatic drain();
        while (text_q.size() != 0 || i_in_valid || run_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender: offers the next byte at the falling edge
    always @(negedge i_clk) begin
        bit go;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            go = text_q.size() != 0 && ($urandom_range(99) >= snd_idle_pct);
            if (go) i_in_data <= text_q.pop_front();
            i_in_valid <= go;
        end
    end

    // Receiver: random stalls plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (rcv_hold > 0) begin
            i_out_ready <= 1'b0;
            rcv_hold--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Monitor: predict on each accepted byte, check each accepted run
    always @(posedge i_clk) begin
        t_out_req want;
        t_out_req run;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                n_bytes++;
                if (scan_byte(i_in_data, run)) run_q.push_back(run);
            end
            if (o_out_valid && i_out_ready) begin
                n_runs++;
                if (run_q.size() == 0) begin
                    $display("%0t: unexpected run: start=%0d end=%0d len=%0d", $time,
                             o_out_data.run_start, o_out_data.run_end, o_out_data.run_length);
                    n_errors++;
                end else begin
                    want = run_q.pop_front();
                    if (want.run_start != o_out_data.run_start) begin
                        $display("%0t: run_start expected %0d, got %0d", $time,
                                 want.run_start, o_out_data.run_start);
                        n_errors++;
                    end
                    if (want.run_end != o_out_data.run_end) begin
                        $display("%0t: run_end expected %0d, got %0d", $time,
                                 want.run_end, o_out_data.run_end);
                        n_errors++;
                    end
                    if (want.run_length != o_out_data.run_length) begin
                        $display("%0t: run_length expected %0d, got %0d", $time,
                                 want.run_length, o_out_data.run_length);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        scanner_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header skipped through newline, a second '>' inside it ignored
        put(CH_HEADER, 1'b0); put(CH_UP_N, 1'b0); put(CH_HEADER, 1'b0);
        put(CH_UP_X, 1'b0); put(CH_NEWLINE, 1'b0);
        // Run of N, n and a zero byte closed by a defined base
        put(CH_UP_N, 1'b0); put(CH_LO_N, 1'b0); put(CH_ZERO, 1'b0); put(CH_UP_A, 1'b0);
        // Newline inside a run does not break it
        put(CH_UP_X, 1'b0); put(CH_NEWLINE, 1'b0); put(CH_LO_Q, 1'b0); put(CH_LO_C, 1'b0);
        // All defined bases, both cases
        put(CH_LO_G, 1'b0); put(CH_LO_T, 1'b0); put(CH_LO_A, 1'b0);
        put(CH_UP_C, 1'b0); put(CH_UP_G, 1'b0); put(CH_UP_T, 1'b0);
        // Run left open across a header, then closed
        put(CH_UP_N, 1'b0); put(CH_HEADER, 1'b0); put(CH_NEWLINE, 1'b0);
        put(CH_HIGH, 1'b0); put(CH_UP_A, 1'b0);
        // Open run flushed by end of stream
        put(CH_MSB, 1'b0); put(CH_HIGH, 1'b1);
        // End of stream on header, newline, single undefined and defined bytes
        put(CH_HEADER, 1'b1); put(CH_NEWLINE, 1'b1); put(CH_UP_N, 1'b1); put(CH_UP_A, 1'b1);
        drain();

        // Free-running phase, then receiver hold-off with a full sender
        fill_random(ITEMS_PER_PHASE);
        drain();
        repeat (60) begin
            put(CH_UP_N, 1'b0);
            put(CH_UP_G, 1'b0);
        end
        rcv_hold = 300;
        drain();

        // Sender mostly idle
        snd_idle_pct = 86;
        fill_random(ITEMS_PER_PHASE);
        drain();

        // Receiver mostly stalled
        snd_idle_pct  = 0;
        rcv_stall_pct = 86;
        fill_random(ITEMS_PER_PHASE);
        drain();

        // Light stalls on both sides
        snd_idle_pct  = 16;
        rcv_stall_pct = 16;
        fill_random(ITEMS_PER_PHASE);
        drain();

        if (run_q.size() != 0) begin
            $display("%0t: %0d runs never reported", $time, run_q.size());
            n_errors++;
        end
        $display("Scanned %0d bytes over four stall mixes and one receiver hold-off,",
                 n_bytes);
        $display("checked %0d reported runs, %0d mismatches", n_runs, n_errors);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/furf_pkg.sv
sv/fasta_undefined_run_finder_core.sv
verif/tb.sv
